// File: rtl/rsort_pkg.sv
package rsort_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_W       = 16;
  localparam int PAY_W       = 32;
  localparam int REC_W       = KEY_W + PAY_W;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CMP,
    ST_PUT,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } rsort_state_t;

  // sequencer -> output register
  typedef struct packed {
    logic load;
    logic last;
    logic ovf;
  } out_ctl_t;

endpackage

// File: rtl/record_insertion_sort_top.sv
// Insertion: ST_START reads the slot below, ST_CMP moves each stored record with a
// larger key up one slot and ST_PUT writes it; a record for a full store is dropped.
// Output: after the final record, the results are read from the dual-port store
// through the output register, each held until the sink takes it.
// Reset clears the entry count, the overflow flag and the output valid; the record
// store is not cleared since only data from written slots is ever used.
module record_insertion_sort_top import rsort_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [REC_W-1:0] s_tdata,  // sort_key[15:0], payload[47:16]
  input  logic             s_tlast,  // final_item
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [REC_W-1:0] m_tdata,  // out_key[15:0], out_payload[47:16]
  output logic             m_tlast,  // last_out
  output logic             m_tuser   // overflow
);

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [REC_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr;
  logic [REC_W-1:0]  rdata;
  out_ctl_t          out_ctl;
  logic              out_done;

  assign out_done = m_tvalid && m_tready;

  rsort_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata),
    .out_ctl  (out_ctl),
    .out_done (out_done)
  );

  rsort_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ctl.load) begin
      m_tvalid <= 1'b1;
    end else if (out_done) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      m_tdata <= rdata;
      m_tlast <= out_ctl.last;
      m_tuser <= out_ctl.ovf;
    end
  end

endmodule

// File: rtl/rsort_ram.sv
module rsort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rsort_seq.sv
module rsort_seq import rsort_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [REC_W-1:0]  s_tdata,
  input  logic              s_tlast,
  output logic              we,
  output logic [ADDR_W-1:0] waddr,
  output logic [REC_W-1:0]  wdata,
  output logic [ADDR_W-1:0] raddr,
  input  logic [REC_W-1:0]  rdata,
  output out_ctl_t          out_ctl,
  input  logic              out_done
);

  rsort_state_t state, state_next;

  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] idx;
  logic [KEY_W-1:0]  new_key;
  logic [PAY_W-1:0]  new_pay;
  logic              new_final;

  logic full;
  logic less;
  logic last_idx;

  assign full     = (cnt == CNT_W'(MAX_ENTRIES));
  // the shared comparator: strict less-than keeps equal keys in arrival order
  assign less     = (new_key < rdata[KEY_W-1:0]);
  assign last_idx = (({1'b0, idx} + CNT_W'(1)) == cnt);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_START;
      end
      ST_START: begin
        if (full) state_next = new_final ? ST_OUT_RD : ST_IDLE;
        else if (pos == '0) state_next = ST_PUT;
        else state_next = ST_CMP;
      end
      ST_CMP: begin
        if (less && pos != ADDR_W'(1)) state_next = ST_CMP;
        else state_next = ST_PUT;
      end
      ST_PUT: begin
        state_next = new_final ? ST_OUT_RD : ST_IDLE;
      end
      ST_OUT_RD:  state_next = ST_OUT_LD;
      ST_OUT_LD:  state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (out_done) state_next = last_idx ? ST_IDLE : ST_OUT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    we       = 1'b0;
    waddr    = pos;
    wdata    = {new_pay, new_key};
    raddr    = pos - ADDR_W'(1);
    out_ctl  = '0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_START: raddr = pos - ADDR_W'(1);
      ST_CMP: begin
        // move the larger record up one slot and fetch the next one down
        if (less) begin
          we    = 1'b1;
          wdata = rdata;
          raddr = pos - ADDR_W'(2);
        end
      end
      ST_PUT:    we = 1'b1;
      ST_OUT_RD: raddr = idx;
      ST_OUT_LD: begin
        raddr        = idx;
        out_ctl.load = 1'b1;
        out_ctl.last = last_idx;
        out_ctl.ovf  = ovf;
      end
      ST_OUT_HOLD: raddr = idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            new_key   <= s_tdata[KEY_W-1:0];
            new_pay   <= s_tdata[REC_W-1:KEY_W];
            new_final <= s_tlast;
            pos       <= cnt[ADDR_W-1:0];
          end
        end
        ST_START: begin
          if (full) begin
            ovf <= 1'b1;
            idx <= '0;
          end
        end
        ST_CMP: begin
          if (less) pos <= pos - ADDR_W'(1);
        end
        ST_PUT: begin
          cnt <= cnt + CNT_W'(1);
          idx <= '0;
        end
        ST_OUT_HOLD: begin
          if (out_done) begin
            if (last_idx) begin
              cnt <= '0;
              ovf <= 1'b0;
            end else begin
              idx <= idx + ADDR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_cmp_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> pos != '0)
    else $error("compare step at slot zero");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_CMP || state == ST_PUT))
    else $error("store written outside insertion");

  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_HOLD && out_done && last_idx) |=> (cnt == '0 && !ovf))
    else $error("set state not cleared after run");

endmodule
